FILE: sv/rodrigues_vector_rotate_top_macros.svh
// assertion macros for the rodrigues vector rotate block
`ifndef RODRIGUES_VECTOR_ROTATE_TOP_MACROS_SVH
`define RODRIGUES_VECTOR_ROTATE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define RVR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RVR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rvr_pkg.sv
// shared types, register codes and rounding helpers for the vector rotator
`timescale 1ns / 1ps

package rvr_pkg;

    localparam int NSTAGES = 5;

    // configuration register indexes
    localparam logic [2:0] REG_AXIS_X    = 3'd0;
    localparam logic [2:0] REG_AXIS_Y    = 3'd1;
    localparam logic [2:0] REG_AXIS_Z    = 3'd2;
    localparam logic [2:0] REG_COS_ANGLE = 3'd3;
    localparam logic [2:0] REG_SIN_ANGLE = 3'd4;

    // register reset values, Q1.15
    localparam logic signed [15:0] AXIS_X_RST    = 16'sd0;
    localparam logic signed [15:0] AXIS_Y_RST    = 16'sd0;
    localparam logic signed [15:0] AXIS_Z_RST    = 16'sd32767;
    localparam logic signed [15:0] COS_ANGLE_RST = 16'sd32767;
    localparam logic signed [15:0] SIN_ANGLE_RST = 16'sd0;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
    } cfg_t;

    typedef struct packed {
        logic signed [23:0] vec_x;
        logic signed [23:0] vec_y;
        logic signed [23:0] vec_z;
    } vec_t;

    typedef struct packed {
        logic signed [23:0] rot_x;
        logic signed [23:0] rot_y;
        logic signed [23:0] rot_z;
    } rot_t;

    // stage 0: raw axis-by-vector products and vector-by-cosine products
    typedef struct packed {
        logic signed [39:0] kyvz;
        logic signed [39:0] kzvy;
        logic signed [39:0] kzvx;
        logic signed [39:0] kxvz;
        logic signed [39:0] kxvy;
        logic signed [39:0] kyvx;
        logic signed [39:0] kxvx;
        logic signed [39:0] kyvy;
        logic signed [39:0] kzvz;
        logic signed [39:0] vcx;
        logic signed [39:0] vcy;
        logic signed [39:0] vcz;
    } prod_t;

    // stage 1: rounded cross product and dot product
    typedef struct packed {
        logic signed [32:0] cx;
        logic signed [32:0] cy;
        logic signed [32:0] cz;
        logic signed [33:0] d;
        logic signed [39:0] vcx;
        logic signed [39:0] vcy;
        logic signed [39:0] vcz;
    } comb_t;

    // stage 2: rounded axis-times-dot and sine term
    typedef struct packed {
        logic signed [34:0] px;
        logic signed [34:0] py;
        logic signed [34:0] pz;
        logic signed [48:0] t2x;
        logic signed [48:0] t2y;
        logic signed [48:0] t2z;
        logic signed [39:0] vcx;
        logic signed [39:0] vcy;
        logic signed [39:0] vcz;
    } scl_t;

    // stage 3: one-minus-cosine term and partial sum of the other two
    typedef struct packed {
        logic signed [52:0] t3x;
        logic signed [52:0] t3y;
        logic signed [52:0] t3z;
        logic signed [49:0] s12x;
        logic signed [49:0] s12y;
        logic signed [49:0] s12z;
    } part_t;

    // load enables of the two scale stages
    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } scl_ctl_t;

    // round half up by 2^8, cross difference
    function automatic logic signed [32:0] rnd_cross(input logic signed [40:0] x);
        logic signed [40:0] t;
        begin
            t = x + 41'sd128;
            return t[40:8];
        end
    endfunction

    // round half up by 2^8, dot sum
    function automatic logic signed [33:0] rnd_dot(input logic signed [41:0] x);
        logic signed [41:0] t;
        begin
            t = x + 42'sd128;
            return t[41:8];
        end
    endfunction

    // round half up by 2^15, axis times dot
    function automatic logic signed [34:0] rnd_kd(input logic signed [49:0] x);
        logic signed [49:0] t;
        begin
            t = x + 50'sd16384;
            return t[49:15];
        end
    endfunction

    // round half up by 2^22 and saturate to Q16.8
    function automatic logic signed [23:0] rnd_sat(input logic signed [53:0] x);
        logic signed [53:0] t;
        logic signed [31:0] r;
        begin
            t = x + 54'sd2097152;
            r = t[53:22];
            if (r > 32'sd8388607) begin
                return 24'sd8388607;
            end else if (r < -32'sd8388608) begin
                return -24'sd8388608;
            end
            return r[23:0];
        end
    endfunction

endpackage

FILE: sv/rvr_prod.sv
// stage 0: axis-by-vector and vector-by-cosine multipliers
`timescale 1ns / 1ps

module rvr_prod (
    input  logic          aclk,
    input  logic          en,
    input  rvr_pkg::cfg_t cfg,
    input  rvr_pkg::vec_t vec,
    output rvr_pkg::prod_t prod
);

    rvr_pkg::prod_t data_reg;
    rvr_pkg::prod_t data_next;

    // twelve independent 16x24 products
    always_comb begin
        data_next.kyvz = cfg.axis_y * vec.vec_z;
        data_next.kzvy = cfg.axis_z * vec.vec_y;
        data_next.kzvx = cfg.axis_z * vec.vec_x;
        data_next.kxvz = cfg.axis_x * vec.vec_z;
        data_next.kxvy = cfg.axis_x * vec.vec_y;
        data_next.kyvx = cfg.axis_y * vec.vec_x;
        data_next.kxvx = cfg.axis_x * vec.vec_x;
        data_next.kyvy = cfg.axis_y * vec.vec_y;
        data_next.kzvz = cfg.axis_z * vec.vec_z;
        data_next.vcx  = cfg.cos_angle * vec.vec_x;
        data_next.vcy  = cfg.cos_angle * vec.vec_y;
        data_next.vcz  = cfg.cos_angle * vec.vec_z;
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign prod = data_reg;

endmodule

FILE: sv/rvr_comb.sv
// stage 1: cross and dot product sums with rounding
`timescale 1ns / 1ps

module rvr_comb (
    input  logic           aclk,
    input  logic           en,
    input  rvr_pkg::prod_t prod,
    output rvr_pkg::comb_t comb
);

    rvr_pkg::comb_t data_reg;
    rvr_pkg::comb_t data_next;

    logic signed [40:0] diff_x;
    logic signed [40:0] diff_y;
    logic signed [40:0] diff_z;
    logic signed [41:0] dot_sum;

    // k x v and k . v in units of 2^-23
    always_comb begin
        diff_x  = 41'(prod.kyvz) - 41'(prod.kzvy);
        diff_y  = 41'(prod.kzvx) - 41'(prod.kxvz);
        diff_z  = 41'(prod.kxvy) - 41'(prod.kyvx);
        dot_sum = 42'(prod.kxvx) + 42'(prod.kyvy) + 42'(prod.kzvz);
    end

    // round to 2^-15
    always_comb begin
        data_next.cx  = rvr_pkg::rnd_cross(diff_x);
        data_next.cy  = rvr_pkg::rnd_cross(diff_y);
        data_next.cz  = rvr_pkg::rnd_cross(diff_z);
        data_next.d   = rvr_pkg::rnd_dot(dot_sum);
        data_next.vcx = prod.vcx;
        data_next.vcy = prod.vcy;
        data_next.vcz = prod.vcz;
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign comb = data_reg;

endmodule

FILE: sv/rvr_scale.sv
// stages 2 and 3: sine term, axis times dot, one-minus-cosine term
`timescale 1ns / 1ps

module rvr_scale (
    input  logic              aclk,
    input  rvr_pkg::scl_ctl_t ctl,
    input  rvr_pkg::cfg_t     cfg,
    input  rvr_pkg::comb_t    comb,
    output rvr_pkg::part_t    part
);

    rvr_pkg::scl_t  scl_reg;
    rvr_pkg::scl_t  scl_next;
    rvr_pkg::part_t part_reg;
    rvr_pkg::part_t part_next;

    logic signed [49:0] kd_x;
    logic signed [49:0] kd_y;
    logic signed [49:0] kd_z;
    logic signed [17:0] omc;

    // axis times dot, rounded, and cross times sine
    always_comb begin
        kd_x = cfg.axis_x * comb.d;
        kd_y = cfg.axis_y * comb.d;
        kd_z = cfg.axis_z * comb.d;
        scl_next.px  = rvr_pkg::rnd_kd(kd_x);
        scl_next.py  = rvr_pkg::rnd_kd(kd_y);
        scl_next.pz  = rvr_pkg::rnd_kd(kd_z);
        scl_next.t2x = comb.cx * cfg.sin_angle;
        scl_next.t2y = comb.cy * cfg.sin_angle;
        scl_next.t2z = comb.cz * cfg.sin_angle;
        scl_next.vcx = comb.vcx;
        scl_next.vcy = comb.vcy;
        scl_next.vcz = comb.vcz;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_mul) begin
            scl_reg <= scl_next;
        end
    end

    // one minus cosine, exact in units of 2^-15
    assign omc = 18'sd32768 - 18'(cfg.cos_angle);

    // third term and sum of the first two, all in units of 2^-30
    always_comb begin
        part_next.t3x  = scl_reg.px * omc;
        part_next.t3y  = scl_reg.py * omc;
        part_next.t3z  = scl_reg.pz * omc;
        part_next.s12x = (50'(scl_reg.vcx) <<< 7) + 50'(scl_reg.t2x);
        part_next.s12y = (50'(scl_reg.vcy) <<< 7) + 50'(scl_reg.t2y);
        part_next.s12z = (50'(scl_reg.vcz) <<< 7) + 50'(scl_reg.t2z);
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_sum) begin
            part_reg <= part_next;
        end
    end

    assign part = part_reg;

endmodule

FILE: sv/rvr_out.sv
// stage 4: final sum, rounding to Q16.8 and saturation
`timescale 1ns / 1ps

module rvr_out (
    input  logic           aclk,
    input  logic           en,
    input  rvr_pkg::part_t part,
    output rvr_pkg::rot_t  rot
);

    rvr_pkg::rot_t data_reg;
    rvr_pkg::rot_t data_next;

    logic signed [53:0] sum_x;
    logic signed [53:0] sum_y;
    logic signed [53:0] sum_z;

    // add the last term, round to 2^-8, clamp
    always_comb begin
        sum_x = 54'(part.s12x) + 54'(part.t3x);
        sum_y = 54'(part.s12y) + 54'(part.t3y);
        sum_z = 54'(part.s12z) + 54'(part.t3z);
        data_next.rot_x = rvr_pkg::rnd_sat(sum_x);
        data_next.rot_y = rvr_pkg::rnd_sat(sum_y);
        data_next.rot_z = rvr_pkg::rnd_sat(sum_z);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign rot = data_reg;

endmodule

FILE: sv/rodrigues_vector_rotate_top.sv
// an accepted input beat passes the prod, comb, scale and out stage registers before its result reaches m_data
// throughput: one vector per cycle while m_ready is high, set by the five-stage multiplier pipeline
// a stalled output backs up the stages; bubbles are still filled while it waits
// reset clears all stage valid bits and restores axis (0,0,1), cos 1, sin 0
// top level: configuration registers, stage valid chain and pipeline stages
`timescale 1ns / 1ps

`include "rodrigues_vector_rotate_top_macros.svh"

module rodrigues_vector_rotate_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rvr_pkg::vec_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rvr_pkg::rot_t m_data,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_wdata
);

    rvr_pkg::cfg_t cfg_reg;
    rvr_pkg::cfg_t cfg_next;

    logic [rvr_pkg::NSTAGES-1:0] vld_reg;
    logic [rvr_pkg::NSTAGES-1:0] vld_next;
    logic [rvr_pkg::NSTAGES-1:0] en;

    rvr_pkg::prod_t    prod;
    rvr_pkg::comb_t    comb;
    rvr_pkg::part_t    part;
    rvr_pkg::scl_ctl_t scl_ctl;

    // configuration register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                rvr_pkg::REG_AXIS_X:    cfg_next.axis_x    = cfg_wdata;
                rvr_pkg::REG_AXIS_Y:    cfg_next.axis_y    = cfg_wdata;
                rvr_pkg::REG_AXIS_Z:    cfg_next.axis_z    = cfg_wdata;
                rvr_pkg::REG_COS_ANGLE: cfg_next.cos_angle = cfg_wdata;
                rvr_pkg::REG_SIN_ANGLE: cfg_next.sin_angle = cfg_wdata;
                default:                cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_x    <= rvr_pkg::AXIS_X_RST;
            cfg_reg.axis_y    <= rvr_pkg::AXIS_Y_RST;
            cfg_reg.axis_z    <= rvr_pkg::AXIS_Z_RST;
            cfg_reg.cos_angle <= rvr_pkg::COS_ANGLE_RST;
            cfg_reg.sin_angle <= rvr_pkg::SIN_ANGLE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // a stage loads when empty or when the stage after it moves on
    always_comb begin
        en[rvr_pkg::NSTAGES-1] = !vld_reg[rvr_pkg::NSTAGES-1] || m_ready;
        for (int i = rvr_pkg::NSTAGES - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    // valid bits follow the data
    always_comb begin
        vld_next[0] = en[0] ? s_valid : vld_reg[0];
        for (int i = 1; i < rvr_pkg::NSTAGES; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[rvr_pkg::NSTAGES-1];

    assign scl_ctl.en_mul = en[2];
    assign scl_ctl.en_sum = en[3];

    // pipeline stages
    rvr_prod u_prod (
        .aclk (aclk),
        .en   (en[0]),
        .cfg  (cfg_reg),
        .vec  (s_data),
        .prod (prod)
    );

    rvr_comb u_comb (
        .aclk (aclk),
        .en   (en[1]),
        .prod (prod),
        .comb (comb)
    );

    rvr_scale u_scale (
        .aclk (aclk),
        .ctl  (scl_ctl),
        .cfg  (cfg_reg),
        .comb (comb),
        .part (part)
    );

    rvr_out u_out (
        .aclk (aclk),
        .en   (en[4]),
        .part (part),
        .rot  (m_data)
    );

    // pipeline control checks
    `RVR_ASSERT_IMP(a_ready_only_when_full, aclk, aresetn, !s_ready, (&vld_reg) && !m_ready, "input stalled while pipeline has room")
    `RVR_ASSERT_NXT(a_accept_fills_s0, aclk, aresetn, s_valid && s_ready, vld_reg[0], "accepted beat did not enter first stage")
    `RVR_ASSERT_NXT(a_s0_holds, aclk, aresetn, vld_reg[0] && !en[1], vld_reg[0], "first stage beat lost while blocked")
    `RVR_ASSERT_IMP(a_out_from_s3, aclk, aresetn, $rose(m_valid), $past(vld_reg[3]), "result appeared without a beat behind it")

endmodule
